### rtl/vffd_pkg.sv
// Shared types, codes and the per-byte decode function of the field decoder.
package vffd_pkg;

    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    localparam logic [1:0] FMT_FIXED   = 2'd0;
    localparam logic [1:0] FMT_UVARINT = 2'd1;
    localparam logic [1:0] FMT_ZIGZAG  = 2'd2;

    localparam logic [1:0] WC_64 = 2'd3;

    localparam logic [1:0] REG_FIELD_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH_CODE   = 2'd1;
    localparam logic [1:0] REG_BYTE_ORDER   = 2'd2;

    localparam logic [7:0] GROUP_MASK = 8'h7f;
    localparam logic [6:0] WIDE_BITS   = 7'd64;
    localparam logic [6:0] NARROW_BITS = 7'd32;
    localparam logic [4:0] WIDE_LIMIT   = 5'd10;
    localparam logic [4:0] NARROW_LIMIT = 5'd5;

    typedef struct packed {
        logic [1:0] field_format;
        logic [1:0] width_code;
        logic       byte_order;
    } t_cfg;

    typedef struct packed {
        t_cfg cfg;
        logic abort;
    } t_cfg_ctrl;

    typedef struct packed {
        logic [3:0] taken;
    } t_stat;

    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  taken;
        logic        done;
        logic [63:0] value;
    } t_step;

    function automatic t_step step_fn(t_cfg cfg, logic [63:0] acc, logic [3:0] taken,
                                      logic [7:0] b);
        t_step       s;
        logic [3:0]  nbytes;
        logic [4:0]  taken_inc;
        logic        wide;
        logic [6:0]  sh;
        logic [63:0] a;
        logic [31:0] r32;
        s         = '0;
        taken_inc = {1'b0, taken} + 5'd1;
        a         = acc;
        if (cfg.field_format == FMT_FIXED) begin
            nbytes = 4'd1 << cfg.width_code;
            if (cfg.byte_order) begin
                a = {acc[55:0], b};
            end else if (taken < 4'd8) begin
                a = acc | ({56'd0, b} << {taken[2:0], 3'b000});
            end
            s.done  = taken_inc >= {1'b0, nbytes};
            s.value = a;
        end else begin
            wide = cfg.width_code == WC_64;
            sh   = 7'(taken) * 7'd7;
            if (sh < (wide ? WIDE_BITS : NARROW_BITS)) begin
                a = acc | ({56'd0, b & GROUP_MASK} << sh[5:0]);
                if (!wide) begin
                    a = {32'd0, a[31:0]};
                end
            end
            s.done = !b[7] || (taken_inc >= (wide ? WIDE_LIMIT : NARROW_LIMIT));
            if (cfg.field_format == FMT_ZIGZAG) begin
                if (wide) begin
                    s.value = (a >> 1) ^ {64{a[0]}};
                end else begin
                    r32     = (a[31:0] >> 1) ^ {32{a[0]}};
                    s.value = {{32{r32[31]}}, r32};
                end
            end else begin
                s.value = a;
            end
        end
        // a finished field leaves a clean accumulator behind
        s.acc   = s.done ? 64'd0 : a;
        s.taken = s.done ? 4'd0 : taken_inc[3:0];
        return s;
    endfunction

endpackage

### rtl/vffd_if.sv
// Valid/ready stream interfaces for input bytes and decoded values.
interface vffd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface vffd_value_if;
    logic        valid;
    logic        ready;
    logic [63:0] decoded_value;
    modport source (output valid, output decoded_value, input ready);
    modport sink   (input valid, input decoded_value, output ready);
endinterface

### rtl/vffd_apb_regs.sv
// APB configuration registers; a write to a defined register aborts the open field.
module vffd_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vffd_pkg::AddrWidth-1:0] paddr,
    input  logic [vffd_pkg::DataWidth-1:0] pwdata,
    output logic [vffd_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    output vffd_pkg::t_cfg_ctrl           o_ctrl
);
    import vffd_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_format <= FMT_FIXED;
            r_cfg.width_code   <= 2'd2;
            r_cfg.byte_order   <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_FIELD_FORMAT: r_cfg.field_format <= pwdata[1:0];
                REG_WIDTH_CODE:   r_cfg.width_code   <= pwdata[1:0];
                REG_BYTE_ORDER:   r_cfg.byte_order   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FIELD_FORMAT: prdata = {30'd0, r_cfg.field_format};
            REG_WIDTH_CODE:   prdata = {30'd0, r_cfg.width_code};
            REG_BYTE_ORDER:   prdata = {31'd0, r_cfg.byte_order};
            default:          prdata = '0;
        endcase
    end

    assign o_ctrl.cfg   = r_cfg;
    assign o_ctrl.abort = wr_en && (idx == REG_FIELD_FORMAT || idx == REG_WIDTH_CODE
                                    || idx == REG_BYTE_ORDER);

endmodule

### rtl/vffd_field_stage.sv
// Input register, field state and result register of the decoder.
module vffd_field_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vffd_pkg::t_cfg_ctrl  i_ctrl,
    vffd_byte_if.sink            i_byte,
    vffd_value_if.source         o_value,
    output vffd_pkg::t_stat      o_stat
);
    import vffd_pkg::*;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic [63:0] r_acc;
    logic [3:0]  r_taken;
    logic        r_out_vld;
    logic [63:0] r_out_value;
    logic        n_out_vld;
    logic        proc;
    t_step       step;

    // the held byte is decoded once the result register can take its result
    assign proc         = r_in_vld && (!r_out_vld || o_value.ready);
    assign i_byte.ready = !r_in_vld || proc;
    assign step         = step_fn(i_ctrl.cfg, r_acc, r_taken, r_in_byte);

    always_comb begin
        if (proc && step.done) begin
            n_out_vld = 1'b1;
        end else if (o_value.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc     <= '0;
            r_taken   <= '0;
        end else begin
            if (i_byte.ready) begin
                r_in_vld <= i_byte.valid;
            end
            r_out_vld <= n_out_vld;
            if (i_ctrl.abort) begin
                r_acc   <= '0;
                r_taken <= '0;
            end else if (proc) begin
                r_acc   <= step.acc;
                r_taken <= step.taken;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
        if (proc && step.done) begin
            r_out_value <= step.value;
        end
    end

    assign o_value.valid         = r_out_vld;
    assign o_value.decoded_value = r_out_value;
    assign o_stat.taken          = r_taken;

endmodule

### rtl/varint_fixed_field_decoder_core.sv
// Top level of the varint and fixed-width field decoder.
// Decodes a serialized byte stream, one byte per item, into one 64-bit value per
// completed field. A byte is taken into an input register, decoded against the field
// state once the result register can take its result, and the value lands in that
// result register. The block takes one byte every cycle unless a byte is held back,
// and a byte is held back only while the result register holds a value the receiver
// has not yet taken. Fixed fields take 1, 2, 4 or 8 bytes in the
// programmed byte order;
// varints end on a byte below 0x80 or after 5 (32-bit) or 10 (64-bit) bytes, and
// zigzag mode returns the signed value sign-extended to 64 bits. Registers sit at
// byte addresses 0 (field_format), 4 (width_code) and 8 (byte_order); writing any of
// them discards a partial field. Write them only while the block is idle.
module varint_fixed_field_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vffd_pkg::AddrWidth-1:0] paddr,
    input  logic [vffd_pkg::DataWidth-1:0] pwdata,
    output logic [vffd_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    vffd_byte_if.sink                     i_byte,
    vffd_value_if.source                  o_value
);
    import vffd_pkg::*;

    t_cfg_ctrl ctrl;
    t_stat     stat;

    vffd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ctrl  (ctrl)
    );

    vffd_field_stage u_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_byte  (i_byte),
        .o_value (o_value),
        .o_stat  (stat)
    );

    a_abort_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.abort |=> stat.taken == 4'd0)
        else $error("field state not cleared after register write");

    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.taken <= 4'd9)
        else $error("byte count beyond longest varint");

    a_fixed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.cfg.field_format == FMT_FIXED |-> stat.taken < (4'd1 << ctrl.cfg.width_code))
        else $error("fixed field ran past its width");

    a_narrow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.cfg.field_format != FMT_FIXED && ctrl.cfg.width_code != WC_64)
        |-> stat.taken < 4'd5)
        else $error("32-bit varint ran past five bytes");

endmodule

### tb/sv/tb_varint_fixed_field_decoder_core.sv
// Self-checking testbench for the varint and fixed-width field decoder core.
module tb_varint_fixed_field_decoder_core;
    import vffd_pkg::*;

    localparam int ITEMS       = 1700;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int SHOW_MAX    = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] FMT_SPARE = 2'd3;
    localparam logic [1:0] REG_NONE  = 2'd3;
    localparam logic [1:0] WC_8      = 2'd0;
    localparam logic [1:0] WC_16     = 2'd1;
    localparam logic [1:0] WC_32     = 2'd2;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        pinned;
        logic [63:0] want;
    } t_dir_row;

    localparam int DIR_ROWS_N = 31;
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        // reset config: fixed, 32 bit, little endian
        '{ROW_BYTE, REG_NONE, 32'h01, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h02, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h03, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h04, 1'b1, 64'h0403_0201},
        '{ROW_CFG,  REG_WIDTH_CODE, 32'(WC_8), 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'hff, 1'b1, 64'hff},
        '{ROW_BYTE, REG_NONE, 32'h00, 1'b1, 64'h0},
        '{ROW_CFG,  REG_WIDTH_CODE, 32'(WC_16), 1'b0, 64'd0},
        '{ROW_CFG,  REG_BYTE_ORDER, 32'd1, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'hab, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'hcd, 1'b1, 64'habcd},
        '{ROW_CFG,  REG_FIELD_FORMAT, 32'(FMT_UVARINT), 1'b0, 64'd0},
        '{ROW_CFG,  REG_WIDTH_CODE, 32'(WC_8), 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h7f, 1'b1, 64'h7f},
        '{ROW_BYTE, REG_NONE, 32'h96, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h01, 1'b1, 64'd150},
        // overlong: fifth byte ends the field, extra bits dropped
        '{ROW_BYTE, REG_NONE, 32'hff, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'hff, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'hff, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'hff, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'hff, 1'b1, 64'hffff_ffff},
        '{ROW_CFG,  REG_FIELD_FORMAT, 32'(FMT_ZIGZAG), 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h01, 1'b1, 64'hffff_ffff_ffff_ffff},
        '{ROW_BYTE, REG_NONE, 32'h02, 1'b1, 64'd1},
        // spare format code acts as unsigned varint
        '{ROW_CFG,  REG_FIELD_FORMAT, 32'(FMT_SPARE), 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h85, 1'b0, 64'd0},
        // write past the registers must not disturb the partial field
        '{ROW_CFG,  REG_NONE, 32'hffff_ffff, 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h01, 1'b1, 64'h85},
        '{ROW_BYTE, REG_NONE, 32'h85, 1'b0, 64'd0},
        // real register write drops the partial field
        '{ROW_CFG,  REG_WIDTH_CODE, 32'(WC_64), 1'b0, 64'd0},
        '{ROW_BYTE, REG_NONE, 32'h03, 1'b1, 64'd3}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [DataWidth-1:0] pwdata;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    vffd_byte_if  in_bytes ();
    vffd_value_if out_values ();

    varint_fixed_field_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_byte  (in_bytes),
        .o_value (out_values)
    );

    always #5 i_clk = ~i_clk;

    // decoder mirror
    logic [1:0]  cfg_format = FMT_FIXED;
    logic [1:0]  cfg_width  = WC_32;
    logic        cfg_order  = 1'b0;
    logic [63:0] acc_bits   = '0;
    logic [3:0]  acc_count  = '0;

    logic [63:0] pending_values[$];
    logic        pin_active = 1'b0;
    logic [63:0] pin_value  = '0;

    int errors      = 0;
    int sent        = 0;
    int checked     = 0;
    int cfg_writes  = 0;
    int phases      = 0;
    int idle_cycles = 0;
    int gap_odds    = 0;
    logic calm      = 1'b0;
    logic hold_req  = 1'b0;

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= SHOW_MAX) begin
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
        end
    endfunction

    function automatic void decode_step(input logic [7:0] b, output logic done,
                                        output logic [63:0] value);
        logic [3:0]  nbytes;
        logic        wide;
        int unsigned shift;
        logic [31:0] half;
        done  = 1'b0;
        value = '0;
        if (cfg_format == FMT_FIXED) begin
            nbytes = 4'd1 << cfg_width;
            if (cfg_order) begin
                acc_bits = {acc_bits[55:0], b};
            end else if (acc_count < 4'd8) begin
                acc_bits |= {56'd0, b} << (8 * acc_count);
            end
            done  = (acc_count + 1) >= nbytes;
            value = acc_bits;
        end else begin
            wide  = cfg_width == WC_64;
            shift = 7 * acc_count;
            if (shift < (wide ? 64 : 32)) begin
                acc_bits |= {57'd0, b[6:0]} << shift;
                if (!wide) begin
                    acc_bits[63:32] = '0;
                end
            end
            done  = !b[7] || ((acc_count + 1) >= (wide ? 10 : 5));
            value = acc_bits;
            if (cfg_format == FMT_ZIGZAG) begin
                if (wide) begin
                    value = (acc_bits >> 1) ^ {64{acc_bits[0]}};
                end else begin
                    half  = (acc_bits[31:0] >> 1) ^ {32{acc_bits[0]}};
                    value = {{32{half[31]}}, half};
                end
            end
        end
        if (done) begin
            acc_bits  = '0;
            acc_count = '0;
        end else begin
            acc_count++;
        end
    endfunction

    // accepted bytes feed the mirror
    always @(posedge i_clk) begin
        logic        done;
        logic [63:0] value;
        if (i_rst_n && in_bytes.valid && in_bytes.ready) begin
            decode_step(in_bytes.data_byte, done, value);
            if (done) begin
                pending_values = {pending_values, (pin_active ? pin_value : value)};
            end
        end
    end

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && out_values.valid && out_values.ready) begin
            if (pending_values.size() == 0) begin
                note_mismatch("unexpected decoded_value", 64'd0, out_values.decoded_value);
            end else begin
                want = pending_values.pop_front();
                checked++;
                if (out_values.decoded_value !== want) begin
                    note_mismatch("decoded_value", want, out_values.decoded_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_bytes.valid && in_bytes.ready) || (out_values.valid && out_values.ready)
                || (psel && penable)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        out_values.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                out_values.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_values.ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end else begin
                out_values.ready = 1'b1;
                repeat ($urandom_range(1, 40)) @(negedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        in_bytes.valid     = 1'b1;
        in_bytes.data_byte = b;
        do @(posedge i_clk); while (!in_bytes.ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_byte(b);
        if (calm || sent >= ITEMS - CALM_ITEMS) begin
            calm = 1'b1;
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_bytes.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        in_bytes.valid = 1'b0;
        while (pending_values.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] word);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FIELD_FORMAT: cfg_format = word[1:0];
            REG_WIDTH_CODE:   cfg_width  = word[1:0];
            REG_BYTE_ORDER:   cfg_order  = word[0];
            default: ;
        endcase
        if (idx != REG_NONE) begin
            acc_bits  = '0;
            acc_count = '0;
        end
        cfg_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [31:0] want);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            note_mismatch("register read", 64'(want), 64'(prdata));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h7f;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one well-formed field in the current format, with occasional noise bytes
    task automatic send_field();
        int         len;
        int         limit;
        logic [7:0] b;
        if (cfg_format == FMT_FIXED) begin
            repeat (1 << cfg_width) put_byte(rand_byte());
        end else begin
            limit = (cfg_width == WC_64) ? 10 : 5;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(1, 3);
                5, 6, 7:       len = $urandom_range(1, limit);
                default:       len = limit;
            endcase
            for (int i = 0; i < len; i++) begin
                b = rand_byte();
                if (i < len - 1) begin
                    b[7] = 1'b1;
                end else if (len < limit) begin
                    b[7] = 1'b0;
                end
                if ($urandom_range(0, 19) == 0) begin
                    b = 8'($urandom_range(0, 255));
                end
                put_byte(b);
            end
        end
    endtask

    initial begin
        logic [31:0] word;
        logic [1:0]  fmt;
        logic [1:0]  wc;
        logic        order;
        int          phase_end;
        int          nbytes;

        in_bytes.valid     = 1'b0;
        in_bytes.data_byte = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS_N; i++) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                wait_idle();
                apb_write(DIR_ROWS[i].reg_idx, DIR_ROWS[i].value);
            end else begin
                pin_active = DIR_ROWS[i].pinned;
                pin_value  = DIR_ROWS[i].want;
                send_byte(DIR_ROWS[i].value[7:0]);
                pin_active = 1'b0;
            end
        end

        while (sent < ITEMS) begin
            wait_idle();
            if (phases < 16) begin
                fmt   = 2'(phases);
                wc    = 2'(phases / 4);
                order = phases[1];
            end else begin
                fmt   = 2'($urandom_range(0, 3));
                wc    = 2'($urandom_range(0, 3));
                order = 1'($urandom_range(0, 1));
            end
            word = $urandom(); word[1:0] = fmt;
            apb_write(REG_FIELD_FORMAT, word);
            word = $urandom(); word[1:0] = wc;
            apb_write(REG_WIDTH_CODE, word);
            word = $urandom(); word[0] = order;
            apb_write(REG_BYTE_ORDER, word);
            if (phases % 3 == 0) begin
                apb_write(REG_NONE, $urandom());
            end
            apb_check(REG_FIELD_FORMAT, {30'd0, fmt});
            apb_check(REG_WIDTH_CODE, {30'd0, wc});
            apb_check(REG_BYTE_ORDER, {31'd0, order});

            gap_odds  = (phases % 4 == 0) ? 0 : $urandom_range(2, 12);
            phase_end = sent + ((phases == 3) ? 120 : $urandom_range(20, 80));
            if (phases == 3) begin
                hold_req = 1'b1;
            end
            while (sent < phase_end && sent < ITEMS) begin
                send_field();
            end
            // leave a partial field for the next register write to drop
            if ($urandom_range(0, 3) == 0) begin
                if (cfg_format != FMT_FIXED) begin
                    repeat ($urandom_range(1, 3)) put_byte(rand_byte() | 8'h80);
                end else begin
                    nbytes = 1 << cfg_width;
                    if (nbytes > 1) begin
                        repeat ($urandom_range(1, nbytes - 1)) put_byte(rand_byte());
                    end
                end
            end
            phases++;
        end

        in_bytes.valid = 1'b0;
        while (pending_values.size() != 0) @(negedge i_clk);
        repeat (SETTLE * 2) @(negedge i_clk);
        if (pending_values.size() != 0) begin
            note_mismatch("results never delivered", 64'(pending_values.size()), 64'd0);
        end

        $display("Sent %0d bytes over %0d config phases, %0d decoded values checked, %0d writes.",
                 sent, phases, checked, cfg_writes);
        $display("Fixed/varint/zigzag at all widths and byte orders, overlong and aborted fields.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
